FILE: rtl/expression_lexer_keyword_classify_defines.svh
// Assertion macros for the expression lexer.
`ifndef EXPRESSION_LEXER_KEYWORD_CLASSIFY_DEFINES_SVH
`define EXPRESSION_LEXER_KEYWORD_CLASSIFY_DEFINES_SVH
`ifndef SYNTH
`define ELK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ELK_ASSERT_RESET(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ELK_ASSERT(label, clk, rst_n, prop)
`define ELK_ASSERT_RESET(label, clk, prop)
`endif
`endif

FILE: rtl/elk_pkg.sv
// Types, codes and keyword tables for the expression lexer.
`timescale 1ns / 1ps
package elk_pkg;
    typedef enum logic [1:0] {MODE_IDLE = 2'd0, MODE_NUMBER = 2'd1, MODE_WORD = 2'd2} mode_t;

    localparam logic [3:0] KIND_NUMBER = 4'd0;
    localparam logic [3:0] KIND_VAR    = 4'd1;
    localparam logic [3:0] KIND_FUNC   = 4'd2;
    localparam logic [3:0] KIND_OP     = 4'd3;
    localparam logic [3:0] KIND_PREFIX = 4'd4;
    localparam logic [3:0] KIND_OPEN   = 4'd5;
    localparam logic [3:0] KIND_CLOSE  = 4'd6;
    localparam logic [3:0] KIND_COMMA  = 4'd7;
    localparam logic [3:0] KIND_ERROR  = 4'd8;
    localparam logic [6:0] NO_CODE     = 7'd127;

    localparam logic [6:0] OP_PLUS  = 7'd0;
    localparam logic [6:0] OP_MINUS = 7'd1;
    localparam logic [6:0] OP_DIV   = 7'd2;
    localparam logic [6:0] OP_MUL   = 7'd3;
    localparam logic [6:0] OP_DOT   = 7'd4;

    localparam int KW_CHARS = 8;
    typedef logic [8*KW_CHARS-1:0] kw_t;

    typedef struct packed {
        logic       hit;
        logic [6:0] code;
    } match_t;

    // Keywords are packed with the first character in the low byte, zero padded.
    function automatic kw_t pack_kw(input string s);
        kw_t r;
        r = '0;
        for (int i = 0; i < s.len() && i < KW_CHARS; i++)
        begin
            r[8*i +: 8] = s[i];
        end
        return r;
    endfunction

    localparam int N_FN = 72;
    localparam int N_SC = 117;
    localparam int N_VEC = 26;

    localparam string FN_WORDS [N_FN] = '{
        "segment5", "segment4", "rot_x", "rot_y", "rot_z", "segment3", "dot3",
        "cross_x", "cross_y", "cross_z", "proj_x", "proj_y", "proj_z", "cubic",
        "quad", "segment2", "dot2", "rot", "vec", "len3", "perp_x", "perp_y",
        "perp_z", "if", "clamp", "lerp", "unit_x", "unit_y", "unit_z", "cross",
        "dot", "proj", "max", "min", "lt", "gt", "lte", "gte", "eq", "neq",
        "atan2", "mod", "div", "pow", "len2", "unit", "len", "perp", "abs",
        "sqrt", "cbrt", "sqr", "cube", "inv", "floor", "ceil", "round", "not",
        "log10", "logN", "sinh", "cosh", "tanh", "asinh", "acosh", "atanh",
        "sin", "cos", "tan", "asin", "acos", "atan"};

    localparam string SC_WORDS [N_SC] = '{
        "r0", "r1", "r2", "r3", "r4", "r5", "r6", "r7", "r8", "r9", "pi",
        "N", "M", "C", "L", "T", "P", "CR", "CD", "x", "y", "z", "r",
        "rn0", "rn1", "rn2", "rn3", "rn4", "rn5", "rn6", "rn7", "rn8", "rn9",
        "n", "D", "spinrate", "t", "l", "fl", "Bx", "By", "Bz", "Br", "tC", "TC",
        "u", "v", "w", "tu", "tv", "tw", "Tu", "Tv", "Tw", "ru", "rv", "rw",
        "tru", "trv", "trw", "Tru", "Trv", "Trw",
        "U", "V", "W", "tU", "tV", "tW", "TU", "TV", "TW", "rU", "rV", "rW",
        "trU", "trV", "trW", "TrU", "TrV", "TrW",
        "i", "j", "k", "ti", "tj", "tk", "Ti", "Tj", "Tk", "ri", "rj", "rk",
        "tri", "trj", "trk", "Tri", "Trj", "Trk",
        "I", "J", "K", "tI", "tJ", "tK", "TI", "TJ", "TK", "rI", "rJ", "rK",
        "trI", "trJ", "trK", "TrI", "TrJ", "TrK"};

    localparam string VEC_WORDS [N_VEC] = '{
        "Bxyz", "uvw", "tuvw", "Tuvw", "ruvw", "truvw", "Truvw",
        "UVW", "tUVW", "TUVW", "rUVW", "trUVW", "TrUVW",
        "ijk", "tijk", "Tijk", "rijk", "trijk", "Trijk",
        "IJK", "tIJK", "TIJK", "rIJK", "trIJK", "TrIJK", "position"};

    // First match wins; the stored word is zero padded past its length.
    function automatic match_t find_fn(input kw_t w);
        match_t m;
        m = '{hit: 1'b0, code: NO_CODE};
        for (int i = N_FN - 1; i >= 0; i--)
        begin
            if (w == pack_kw(FN_WORDS[i])) m = '{hit: 1'b1, code: 7'(i)};
        end
        return m;
    endfunction

    function automatic match_t find_sc(input kw_t w);
        match_t m;
        m = '{hit: 1'b0, code: NO_CODE};
        for (int i = N_SC - 1; i >= 0; i--)
        begin
            if (w == pack_kw(SC_WORDS[i])) m = '{hit: 1'b1, code: 7'(i)};
        end
        return m;
    endfunction

    function automatic match_t find_vec(input kw_t w);
        match_t m;
        m = '{hit: 1'b0, code: NO_CODE};
        for (int i = N_VEC - 1; i >= 0; i--)
        begin
            if (w == pack_kw(VEC_WORDS[i])) m = '{hit: 1'b1, code: 7'(i)};
        end
        return m;
    endfunction
endpackage

FILE: rtl/expression_lexer_keyword_classify.sv
// Expression lexer: one character per cycle in, up to two tokens per character out.
// The first token of a character is valid in the cycle after the character is taken.
// Throughput: one character per cycle while the output is taken and each character
// causes at most one token; a character causing two tokens holds off the input
// while its second token moves from the spill register to the output register.
// Reset: scan idle, position and lengths zero, prev-operator set, output empty.
`timescale 1ns / 1ps
`include "expression_lexer_keyword_classify_defines.svh"
module expression_lexer_keyword_classify
    import elk_pkg::*;
#(
    parameter int MAX_KEYWORD = 8,
    parameter int POS_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          ch,
    input  logic                last_char,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3:0]          token_kind,
    output logic [6:0]          token_code,
    output logic                is_vector,
    output logic [POS_BITS-1:0] token_start,
    output logic [POS_BITS-1:0] token_length,
    output logic                last_of_run
);
    localparam int IDX_BITS = $clog2(MAX_KEYWORD);
    localparam logic [POS_BITS-1:0] LEN_MAX = '1;

    typedef struct packed {
        logic [3:0]          kind;
        logic [6:0]          sub;
        logic                vec;
        logic [POS_BITS-1:0] start;
        logic [POS_BITS-1:0] len;
        logic                last;
    } tok_t;

    mode_t               mode_reg, mode_next;
    logic                prev_op_reg, prev_op_next;
    logic [7:0]          word_reg [MAX_KEYWORD];
    logic [POS_BITS-1:0] plen_reg, plen_next;
    logic [POS_BITS-1:0] pstart_reg, pstart_next;
    logic [POS_BITS-1:0] pos_reg;

    tok_t out_reg, spill_reg;
    logic out_vld_reg, spill_vld_reg;

    kw_t    wbuf;
    match_t m_fn, m_sc, m_vec;
    tok_t   end_tok, flush_tok, char_tok, t0, t1;
    logic   is_dig, is_let, ends, has_char, flush, n0, n1;
    logic   take, wr_en, start_new, use_cur;
    logic [POS_BITS-1:0] cls_len;
    logic [3:0]          cls_kind;
    logic [6:0]          cls_sub;
    logic                cls_vec;
    logic [IDX_BITS-1:0] wr_idx;

    assign take = in_valid && in_ready;

    always_comb
    begin
        is_dig = ch inside {["0":"9"]};
        is_let = ch inside {["a":"z"], ["A":"Z"], "_"};
        ends = (mode_reg == MODE_NUMBER && !(is_dig || ch == ".")) ||
               (mode_reg == MODE_WORD && !(is_dig || is_let));
        mode_next = mode_reg;
        prev_op_next = prev_op_reg;
        plen_next = plen_reg;
        pstart_next = pstart_reg;
        start_new = 1'b0;
        wr_en = 1'b0;
        has_char = 1'b0;
        char_tok = '{kind: KIND_ERROR, sub: NO_CODE, vec: 1'b0,
                     start: pos_reg, len: POS_BITS'(1), last: 1'b0};
        if (ends)
        begin
            prev_op_next = 1'b0;
            mode_next = MODE_IDLE;
        end
        if (mode_reg != MODE_IDLE && !ends)
        begin
            wr_en = 1'b1;
            if (plen_reg < LEN_MAX) plen_next = plen_reg + 1'b1;
        end
        else if (is_dig || is_let)
        begin
            mode_next = is_dig ? MODE_NUMBER : MODE_WORD;
            pstart_next = pos_reg;
            plen_next = POS_BITS'(1);
            start_new = 1'b1;
            wr_en = 1'b1;
        end
        else
        begin
            has_char = (ch != " ");
            case (ch)
                "+", "-":
                begin
                    char_tok.sub = (ch == "+") ? OP_PLUS : OP_MINUS;
                    if (prev_op_next)
                    begin
                        char_tok.kind = KIND_PREFIX;
                    end
                    else
                    begin
                        char_tok.kind = KIND_OP;
                        prev_op_next = 1'b1;
                    end
                end
                "/", "*", ".":
                begin
                    char_tok.kind = KIND_OP;
                    char_tok.sub = (ch == "/") ? OP_DIV : (ch == "*") ? OP_MUL : OP_DOT;
                    prev_op_next = 1'b1;
                end
                "(":
                begin
                    char_tok.kind = KIND_OPEN;
                    prev_op_next = 1'b1;
                end
                ")":
                begin
                    char_tok.kind = KIND_CLOSE;
                    prev_op_next = 1'b0;
                end
                ",":
                begin
                    char_tok.kind = KIND_COMMA;
                    prev_op_next = 1'b1;
                end
                default:
                begin
                    prev_op_next = (ch == " ") ? prev_op_next : 1'b0;
                end
            endcase
        end
    end

    // Only one word needs a keyword match per character: the word that ends here,
    // or else the word as it stands after this character, for the final flush.
    always_comb
    begin
        use_cur = ends && (mode_reg == MODE_WORD);
        cls_len = use_cur ? plen_reg : plen_next;
        wbuf = '0;
        for (int i = 0; i < KW_CHARS; i++)
        begin
            if (start_new)
            begin
                if (i == 0) wbuf[7:0] = ch;
            end
            else if (i < MAX_KEYWORD && POS_BITS'(i) < plen_reg)
            begin
                wbuf[8*i +: 8] = word_reg[i];
            end
            else if (!use_cur && wr_en && POS_BITS'(i) == plen_reg)
            begin
                wbuf[8*i +: 8] = ch;
            end
        end
    end

    assign m_fn  = find_fn(wbuf);
    assign m_sc  = find_sc(wbuf);
    assign m_vec = find_vec(wbuf);

    // Words longer than the longest keyword are unknown variables.
    always_comb
    begin
        cls_kind = KIND_VAR;
        cls_sub = NO_CODE;
        cls_vec = 1'b0;
        if (cls_len <= POS_BITS'(KW_CHARS))
        begin
            if (m_fn.hit)
            begin
                cls_kind = KIND_FUNC;
                cls_sub = m_fn.code;
            end
            else if (m_sc.hit)
            begin
                cls_sub = m_sc.code;
            end
            else if (m_vec.hit)
            begin
                cls_sub = m_vec.code;
                cls_vec = 1'b1;
            end
        end
    end

    always_comb
    begin
        end_tok = '{kind: (mode_reg == MODE_NUMBER) ? KIND_NUMBER : cls_kind,
                    sub: (mode_reg == MODE_NUMBER) ? NO_CODE : cls_sub,
                    vec: (mode_reg == MODE_NUMBER) ? 1'b0 : cls_vec,
                    start: pstart_reg, len: plen_reg, last: 1'b0};
        flush_tok = '{kind: (mode_next == MODE_NUMBER) ? KIND_NUMBER : cls_kind,
                      sub: (mode_next == MODE_NUMBER) ? NO_CODE : cls_sub,
                      vec: (mode_next == MODE_NUMBER) ? 1'b0 : cls_vec,
                      start: pstart_next, len: plen_next, last: 1'b0};
    end

    // Token order: the token that ends here, then this character, then the final flush.
    always_comb
    begin
        flush = last_char && (mode_next != MODE_IDLE);
        t0 = end_tok;
        t1 = char_tok;
        n0 = 1'b0;
        n1 = 1'b0;
        if (ends)
        begin
            n0 = 1'b1;
            if (has_char)
            begin
                n1 = 1'b1;
            end
            else if (flush)
            begin
                t1 = flush_tok;
                n1 = 1'b1;
            end
        end
        else if (has_char)
        begin
            t0 = char_tok;
            n0 = 1'b1;
        end
        else if (flush)
        begin
            t0 = flush_tok;
            n0 = 1'b1;
        end
        if (n1) t1.last = 1'b1;
        else t0.last = 1'b1;
    end

    assign wr_idx = IDX_BITS'(start_new ? '0 : plen_reg);

    assign in_ready = !spill_vld_reg && (!out_vld_reg || out_ready);

    always_ff @(posedge clk)
    begin
        if (take && wr_en && (start_new || int'(plen_reg) < MAX_KEYWORD))
        begin
            word_reg[wr_idx] <= ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            prev_op_reg <= 1'b1;
            plen_reg <= '0;
            pstart_reg <= '0;
            pos_reg <= '0;
            out_vld_reg <= 1'b0;
            spill_vld_reg <= 1'b0;
            out_reg <= '0;
            spill_reg <= '0;
        end
        else
        begin
            if (take)
            begin
                if (n0) out_reg <= t0;
                out_vld_reg <= n0;
                if (n1)
                begin
                    spill_reg <= t1;
                    spill_vld_reg <= 1'b1;
                end
                if (last_char)
                begin
                    mode_reg <= MODE_IDLE;
                    prev_op_reg <= 1'b1;
                    plen_reg <= '0;
                    pstart_reg <= '0;
                    pos_reg <= '0;
                end
                else
                begin
                    mode_reg <= mode_next;
                    prev_op_reg <= prev_op_next;
                    plen_reg <= plen_next;
                    pstart_reg <= pstart_next;
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            else if (spill_vld_reg && (!out_vld_reg || out_ready))
            begin
                out_reg <= spill_reg;
                out_vld_reg <= 1'b1;
                spill_vld_reg <= 1'b0;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_vld_reg;
    assign token_kind   = out_reg.kind;
    assign token_code   = out_reg.sub;
    assign is_vector    = out_reg.vec;
    assign token_start  = out_reg.start;
    assign token_length = out_reg.len;
    assign last_of_run  = out_reg.last;

    `ELK_ASSERT(a_spill_needs_out, clk, rst_n, spill_vld_reg |-> out_vld_reg)
    `ELK_ASSERT(a_no_take_when_busy, clk, rst_n, spill_vld_reg |-> !in_ready)
    `ELK_ASSERT(a_vec_is_var, clk, rst_n, (out_vld_reg && out_reg.vec) |-> out_reg.kind == KIND_VAR)
    `ELK_ASSERT_RESET(a_reset_idle, clk, !rst_n |=> mode_reg == MODE_IDLE || rst_n)
endmodule

FILE: tb/tb_expression_lexer_keyword_classify.sv
// Self-checking testbench for the expression lexer with keyword classification.
`timescale 1ns / 1ps
module tb_expression_lexer_keyword_classify
    import elk_pkg::*;
();

    localparam int CYCLE_LIMIT = 600000;
    localparam string WORD_CHARS =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    localparam string OP_CHARS = "+-/*.";

    typedef struct {
        logic [3:0]  kind;
        logic [6:0]  sub;
        logic        vec;
        logic [11:0] start;
        logic [11:0] len;
        logic        lst;
    } token_t;

    typedef struct {
        logic [7:0]  c;
        logic        l;
        bit          typed;
        logic [3:0]  kind;
        logic [6:0]  sub;
        logic [11:0] start;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  ch;
    logic        last_char;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  token_kind;
    logic [6:0]  token_code;
    logic        is_vector;
    logic [11:0] token_start;
    logic [11:0] token_length;
    logic        last_of_run;

    expression_lexer_keyword_classify uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .ch(ch), .last_char(last_char),
        .out_valid(out_valid), .out_ready(out_ready),
        .token_kind(token_kind), .token_code(token_code), .is_vector(is_vector),
        .token_start(token_start), .token_length(token_length),
        .last_of_run(last_of_run)
    );

    token_t      token_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          hold_req = 0;
    int          burst_left = 0;
    int          sent = 0;

    // Lexer state mirrored by the predictor.
    mode_t       scan_mode;
    logic        prev_op;
    logic [7:0]  word_buf[8];
    logic [11:0] pend_len;
    logic [11:0] pend_start;
    logic [11:0] char_pos;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
            if (clk)
            begin
                cycles++;
                if (cycles > CYCLE_LIMIT)
                begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    function automatic token_t make_tok(logic [3:0] kind, logic [6:0] sub, logic vec,
                                        logic [11:0] start, logic [11:0] len);
        token_t t;
        t = '{kind: kind, sub: sub, vec: vec, start: start, len: len, lst: 1'b0};
        return t;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    // Only the characters actually stored are compared; long words never match.
    function automatic bit word_is(string kw);
        if (pend_len > 8 || kw.len() != int'(pend_len))
            return 1'b0;
        for (int i = 0; i < kw.len(); i++)
            if (kw[i] != word_buf[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void clear_state();
        scan_mode = MODE_IDLE;
        prev_op = 1'b1;
        pend_len = '0;
        pend_start = '0;
        char_pos = '0;
    endfunction

    function automatic void add_char(logic [7:0] c);
        if (pend_len < 8)
            word_buf[pend_len[2:0]] = c;
        if (pend_len != 12'hFFF)
            pend_len++;
    endfunction

    function automatic void flush_word(ref token_t oq[$]);
        int code;
        logic [3:0] kind;
        logic vec;
        code = -1;
        vec = 1'b0;
        kind = KIND_VAR;
        if (scan_mode == MODE_NUMBER)
            oq.push_back(make_tok(KIND_NUMBER, NO_CODE, 1'b0, pend_start, pend_len));
        else
        begin
            for (int i = 0; i < N_FN && code < 0; i++)
                if (word_is(FN_WORDS[i])) code = i;
            if (code >= 0)
                kind = KIND_FUNC;
            for (int i = 0; i < N_SC && code < 0; i++)
                if (word_is(SC_WORDS[i])) code = i;
            for (int i = 0; i < N_VEC && code < 0; i++)
                if (word_is(VEC_WORDS[i]))
                begin
                    code = i;
                    vec = 1'b1;
                end
            oq.push_back(make_tok(kind, code < 0 ? NO_CODE : 7'(code), vec,
                                  pend_start, pend_len));
        end
        scan_mode = MODE_IDLE;
        pend_len = '0;
        pend_start = '0;
    endfunction

    // Works out the tokens caused by one accepted character.
    function automatic void lex_char(logic [7:0] c, logic l);
        token_t oq[$];
        logic [6:0] code;
        if (scan_mode == MODE_NUMBER)
        begin
            if (is_digit(c) || c == ".")
                add_char(c);
            else
            begin
                flush_word(oq);
                prev_op = 1'b0;
            end
        end
        else if (scan_mode == MODE_WORD)
        begin
            if (is_letter(c) || is_digit(c))
                add_char(c);
            else
            begin
                flush_word(oq);
                prev_op = 1'b0;
            end
        end
        if (scan_mode == MODE_IDLE)
        begin
            if (is_digit(c) || is_letter(c))
            begin
                scan_mode = is_digit(c) ? MODE_NUMBER : MODE_WORD;
                pend_start = char_pos;
                pend_len = '0;
                add_char(c);
            end
            else if (c == "+" || c == "-" || c == "/" || c == "*" || c == ".")
            begin
                code = c == "+" ? OP_PLUS : c == "-" ? OP_MINUS : c == "/" ? OP_DIV :
                       c == "*" ? OP_MUL : OP_DOT;
                if (prev_op && (code == OP_PLUS || code == OP_MINUS))
                    oq.push_back(make_tok(KIND_PREFIX, code, 1'b0, char_pos, 12'd1));
                else
                begin
                    oq.push_back(make_tok(KIND_OP, code, 1'b0, char_pos, 12'd1));
                    prev_op = 1'b1;
                end
            end
            else if (c == "(")
            begin
                oq.push_back(make_tok(KIND_OPEN, NO_CODE, 1'b0, char_pos, 12'd1));
                prev_op = 1'b1;
            end
            else if (c == ")")
            begin
                oq.push_back(make_tok(KIND_CLOSE, NO_CODE, 1'b0, char_pos, 12'd1));
                prev_op = 1'b0;
            end
            else if (c == ",")
            begin
                oq.push_back(make_tok(KIND_COMMA, NO_CODE, 1'b0, char_pos, 12'd1));
                prev_op = 1'b1;
            end
            else if (c != " ")
            begin
                oq.push_back(make_tok(KIND_ERROR, NO_CODE, 1'b0, char_pos, 12'd1));
                prev_op = 1'b0;
            end
        end
        char_pos++;
        if (l)
        begin
            if (scan_mode != MODE_IDLE)
                flush_word(oq);
            clear_state();
        end
        if (oq.size() > 0)
            oq[oq.size() - 1].lst = 1'b1;
        foreach (oq[i])
            token_q.push_back(oq[i]);
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0d, expected %0d at cycle %0d",
                 field, got, want, cycles);
        errors++;
    endtask

    // Sender: bursts of random length, random gaps; valid held across a burst.
    task automatic send(logic [7:0] c, logic l);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        in_valid = 1'b1;
        ch = c;
        last_char = l;
        do @(posedge clk); while (!in_ready);
        lex_char(c, l);
        burst_left--;
        sent++;
        @(negedge clk);
    endtask

    task automatic send_expr(logic [7:0] s[$]);
        foreach (s[i])
            send(s[i], i == s.size() - 1);
    endtask

    task automatic push_word(ref logic [7:0] s[$], input string w);
        for (int i = 0; i < w.len(); i++)
            s.push_back(w[i]);
    endtask

    task automatic random_expr();
        logic [7:0] s[$];
        int n;
        int r;
        n = $urandom_range(1, 8);
        if ($urandom_range(0, 9) == 0)
        begin
            repeat (n) s.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat (n)
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                    push_word(s, FN_WORDS[$urandom_range(0, N_FN - 1)]);
                else if (r < 22)
                    push_word(s, SC_WORDS[$urandom_range(0, N_SC - 1)]);
                else if (r < 30)
                    push_word(s, VEC_WORDS[$urandom_range(0, N_VEC - 1)]);
                else if (r < 40)
                begin
                    s.push_back(WORD_CHARS[$urandom_range(0, 52)]);
                    repeat ($urandom_range(0, 11))
                        s.push_back(WORD_CHARS[$urandom_range(0, 62)]);
                end
                else if (r < 55)
                begin
                    s.push_back(8'("0" + $urandom_range(0, 9)));
                    repeat ($urandom_range(0, 5))
                        s.push_back($urandom_range(0, 5) == 0 ? 8'(".")
                                    : 8'("0" + $urandom_range(0, 9)));
                end
                else if (r < 72)
                    s.push_back(OP_CHARS[$urandom_range(0, 4)]);
                else if (r < 80)
                    s.push_back("(");
                else if (r < 87)
                    s.push_back(")");
                else if (r < 92)
                    s.push_back(",");
                else if (r < 96)
                    s.push_back(" ");
                else
                    s.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) == 0)
                    s.push_back(" ");
            end
        end
        send_expr(s);
    endtask

    // Receiver: random ready with a duty cycle redrawn from 100, 70 or 25 percent; long hold-offs on request.
    initial
    begin
        int duty;
        int hold_left;
        duty = 100;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (cycles % 64 == 0)
                duty = $urandom_range(0, 2) == 0 ? 100 : $urandom_range(0, 1) ? 70 : 25;
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else
                out_ready = $urandom_range(0, 99) < duty;
        end
    end

    always @(posedge clk)
    begin
        token_t t;
        if (rst_n && out_valid && out_ready)
        begin
            if (token_q.size() == 0)
            begin
                report("unexpected token_kind", token_kind, 0);
            end
            else
            begin
                t = token_q.pop_front();
                if (token_kind !== t.kind) report("token_kind", token_kind, t.kind);
                if (token_code !== t.sub) report("token_code", token_code, t.sub);
                if (is_vector !== t.vec) report("is_vector", is_vector, t.vec);
                if (token_start !== t.start) report("token_start", token_start, t.start);
                if (token_length !== t.len) report("token_length", token_length, t.len);
                if (last_of_run !== t.lst) report("last_of_run", last_of_run, t.lst);
            end
        end
    end

    initial
    begin
        row_t rows[26];
        logic [7:0] s[$];
        int expr_count;
        int waited;
        rows = '{
            '{"(", 0, 1, KIND_OPEN, NO_CODE, 12'd0},
            '{"-", 0, 1, KIND_PREFIX, OP_MINUS, 12'd1},
            '{"x", 0, 0, 0, 0, 0}, '{"y", 0, 0, 0, 0, 0}, '{"z", 0, 0, 0, 0, 0},
            '{"+", 0, 0, 0, 0, 0}, '{"9", 0, 0, 0, 0, 0}, '{".", 0, 0, 0, 0, 0},
            '{"0", 0, 0, 0, 0, 0}, '{")", 0, 0, 0, 0, 0},
            '{8'hFF, 0, 1, KIND_ERROR, NO_CODE, 12'd10},
            '{8'h80, 0, 1, KIND_ERROR, NO_CODE, 12'd11},
            '{" ", 0, 0, 0, 0, 0}, '{"/", 0, 0, 0, 0, 0}, '{"*", 0, 0, 0, 0, 0},
            '{"-", 0, 0, 0, 0, 0},
            '{"p", 0, 0, 0, 0, 0}, '{"o", 0, 0, 0, 0, 0}, '{"s", 0, 0, 0, 0, 0},
            '{"i", 0, 0, 0, 0, 0}, '{"t", 0, 0, 0, 0, 0}, '{"i", 0, 0, 0, 0, 0},
            '{"o", 0, 0, 0, 0, 0}, '{"n", 1, 0, 0, 0, 0},
            '{8'h00, 1, 1, KIND_ERROR, NO_CODE, 12'd0},
            '{"_", 1, 0, 0, 0, 0}};
        rst_n = 1'b0;
        in_valid = 1'b0;
        ch = 8'h00;
        last_char = 1'b0;
        clear_state();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            send(rows[i].c, rows[i].l);
            // Rows with a typed expectation each cause exactly one token.
            if (rows[i].typed)
            begin
                void'(token_q.pop_back());
                token_q.push_back('{kind: rows[i].kind, sub: rows[i].sub, vec: 1'b0,
                                    start: rows[i].start, len: 12'd1, lst: 1'b1});
            end
        end

        // A word far longer than any keyword comes out as an unknown variable.
        repeat (60) s.push_back(WORD_CHARS[$urandom_range(0, 25)]);
        push_word(s, " +1");
        send_expr(s);

        expr_count = 0;
        while (sent < 1750)
        begin
            if (expr_count == 30)
                hold_req = 300;
            if (expr_count == 60)
            begin
                in_valid = 1'b0;
                burst_left = 0;
                while (token_q.size() != 0) @(negedge clk);
            end
            random_expr();
            expr_count++;
        end
        in_valid = 1'b0;

        waited = 0;
        while (token_q.size() != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (20) @(negedge clk);
        if (errors == 0 && token_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
